@@ src/scoped_root_table_assert.svh @@
// Assertion macros used by the scoped root table checker.
`ifndef SCOPED_ROOT_TABLE_ASSERT_SVH
`define SCOPED_ROOT_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/srt_pkg.sv @@
// Shared types and constants of the scoped root table.
`default_nettype none

package srt_pkg;

	localparam int unsigned DEPTH_DEF     = 64;
	localparam int unsigned MAX_SCOPE_DEF = 255;

	localparam int unsigned FUNC_W   = 3;
	localparam int unsigned ID_W     = 64;
	localparam int unsigned REF_W    = 64;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned SCOPE_W  = 8;

	typedef enum logic [FUNC_W-1:0] {
		FN_INIT     = 3'd0,
		FN_REASSIGN = 3'd1,
		FN_REMOVE   = 3'd2,
		FN_PUSH     = 3'd3,
		FN_POP      = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_EXISTS      = 3'd1,
		ST_MISSING     = 3'd2,
		ST_FULL        = 3'd3,
		ST_SCOPE_LIMIT = 3'd4,
		ST_POP_IGNORED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_POP_RD,
		S_POP_CMP
	} state_t;

	// write enables toward the entry store
	typedef struct packed {
		logic entry_we;  // ident and level
		logic ref_we;
	} store_wr_t;

endpackage

`default_nettype wire

@@ src/srt_store.sv @@
// Entry store: id, level and reference memories with one registered read port.
`default_nettype none

module srt_store #(
	parameter int unsigned DEPTH = srt_pkg::DEPTH_DEF,
	parameter int unsigned LVL_W = 8,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire srt_pkg::store_wr_t       wr,
	input  wire logic [AW-1:0]            wr_addr,
	input  wire logic [srt_pkg::ID_W-1:0] wr_ident,
	input  wire logic [LVL_W-1:0]         wr_level,
	input  wire logic [srt_pkg::REF_W-1:0] wr_ref,
	input  wire logic [AW-1:0]            rd_addr,
	output logic [srt_pkg::ID_W-1:0]      rd_ident,
	output logic [LVL_W-1:0]              rd_level
);
	import srt_pkg::*;

	logic [ID_W-1:0]  ident_mem [DEPTH];
	logic [LVL_W-1:0] level_mem [DEPTH];
	logic [REF_W-1:0] ref_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.entry_we) begin
			ident_mem[wr_addr] <= wr_ident;
			level_mem[wr_addr] <= wr_level;
		end
		if (wr.ref_we) begin
			ref_mem[wr_addr] <= wr_ref;
		end
	end

	always_ff @(posedge clk) begin
		rd_ident <= ident_mem[rd_addr];
		rd_level <= level_mem[rd_addr];
	end

endmodule

`default_nettype wire

@@ src/scoped_root_table.sv @@
// Scoped root table top level: root-set stack with id search and scope pops.
//
//  channel  | handshake            | fields
//  ---------+----------------------+---------------------------------------
//  command  | start, busy          | func, var_id, ref_value, force_pop
//  result   | done (one-cycle)     | status, entry_count, scope_level
//
// Push scope, ignored pops and unknown codes answer in the cycle after
// acceptance and never raise busy. Init, reassign and remove scan the entries
// one a cycle through the store's registered read port. A pop removes top
// entries of the current scope level one by one, then lowers the scope level.
// Reset (arst_n low) empties the table and sets the scope level to one.
// The receiver cannot stall: done is high for exactly one cycle.
`default_nettype none

module scoped_root_table #(
	parameter int unsigned DEPTH     = srt_pkg::DEPTH_DEF,
	parameter int unsigned MAX_SCOPE = srt_pkg::MAX_SCOPE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [srt_pkg::FUNC_W-1:0]    func,
	input  wire logic [srt_pkg::ID_W-1:0]      var_id,
	input  wire logic [srt_pkg::REF_W-1:0]     ref_value,
	input  wire logic                          force_pop,
	output logic                               done,
	output logic [srt_pkg::STATUS_W-1:0]       status,
	output logic [srt_pkg::COUNT_W-1:0]        entry_count,
	output logic [srt_pkg::SCOPE_W-1:0]        scope_level
);
	import srt_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned LW = $clog2(MAX_SCOPE + 1);

	// sequencer and table state
	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [LW-1:0]     lvl_q, lvl_d;
	logic [CW-1:0]     addr_q, addr_d;
	logic              vld_s1;
	logic [AW-1:0]     idx_s1;
	logic              res_vld_q, res_vld_d;
	status_t           res_st_q, res_st_d;

	// captured command payload
	logic [FUNC_W-1:0] func_q;
	logic [ID_W-1:0]   id_q;
	logic [REF_W-1:0]  ref_q;

	// store interface
	store_wr_t         wr;
	logic [AW-1:0]     wr_addr;
	logic [REF_W-1:0]  ref_wdata;
	logic [AW-1:0]     rd_addr;
	logic [ID_W-1:0]   ident_rd;
	logic [LW-1:0]     level_rd;

	logic              issue;
	logic              match;
	logic [CW-1:0]     cnt_m1;

	assign cnt_m1 = cnt_q - CW'(1);
	assign match  = vld_s1 && (ident_rd == id_q);

	srt_store #(
		.DEPTH (DEPTH),
		.LVL_W (LW),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.wr_ident (id_q),
		.wr_level (lvl_q),
		.wr_ref   (ref_wdata),
		.rd_addr  (rd_addr),
		.rd_ident (ident_rd),
		.rd_level (level_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			lvl_q     <= LW'(1);
			addr_q    <= '0;
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
			res_st_q  <= ST_OK;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			lvl_q     <= lvl_d;
			addr_q    <= addr_d;
			vld_s1    <= issue;
			res_vld_q <= res_vld_d;
			res_st_q  <= res_st_d;
		end
	end

	// payload and search-pipe index, no reset needed
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q[AW-1:0];
		if (start && !busy) begin
			func_q <= func;
			id_q   <= var_id;
			ref_q  <= ref_value;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		lvl_d     = lvl_q;
		addr_d    = addr_q;
		res_vld_d = 1'b0;
		res_st_d  = res_st_q;
		wr        = '0;
		wr_addr   = cnt_q[AW-1:0];
		ref_wdata = ref_q;
		rd_addr   = addr_q[AW-1:0];
		issue     = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (func)
						FN_INIT, FN_REASSIGN, FN_REMOVE: begin
							addr_d  = '0;
							state_d = S_SEARCH;
						end
						FN_PUSH: begin
							res_vld_d = 1'b1;
							if (lvl_q >= LW'(MAX_SCOPE)) begin
								lvl_d    = LW'(MAX_SCOPE);
								res_st_d = ST_SCOPE_LIMIT;
							end else begin
								lvl_d    = lvl_q + LW'(1);
								res_st_d = ST_OK;
							end
						end
						FN_POP: begin
							if ((lvl_q == '0) || ((lvl_q <= LW'(1)) && !force_pop)) begin
								res_vld_d = 1'b1;
								res_st_d  = ST_POP_IGNORED;
							end else begin
								state_d = S_POP_RD;
							end
						end
						default: begin
							// unused codes: answer ok, change nothing
							res_vld_d = 1'b1;
							res_st_d  = ST_OK;
						end
					endcase
				end
			end

			S_SEARCH: begin
				// read entry addr_q now, compare it next cycle
				issue = addr_q < cnt_q;
				if (issue) begin
					addr_d = addr_q + CW'(1);
				end
				if (match || (!issue && !vld_s1)) begin
					state_d   = S_IDLE;
					res_vld_d = 1'b1;
					case (func_q)
						FN_INIT: begin
							if (match) begin
								res_st_d = ST_EXISTS;
							end else if (cnt_q == CW'(DEPTH)) begin
								res_st_d = ST_FULL;
							end else begin
								wr.entry_we = 1'b1;
								wr.ref_we   = 1'b1;
								cnt_d       = cnt_q + CW'(1);
								res_st_d    = ST_OK;
							end
						end
						default: begin
							if (!match) begin
								res_st_d = ST_MISSING;
							end else begin
								wr.ref_we = 1'b1;
								wr_addr   = idx_s1;
								ref_wdata = (func_q == FN_REASSIGN) ? ref_q : '0;
								res_st_d  = ST_OK;
							end
						end
					endcase
				end
			end

			S_POP_RD: begin
				if (cnt_q == '0) begin
					lvl_d     = lvl_q - LW'(1);
					res_st_d  = ST_OK;
					res_vld_d = 1'b1;
					state_d   = S_IDLE;
				end else begin
					rd_addr = cnt_m1[AW-1:0];
					state_d = S_POP_CMP;
				end
			end

			S_POP_CMP: begin
				if (level_rd == lvl_q) begin
					cnt_d   = cnt_m1;
					state_d = S_POP_RD;
				end else begin
					lvl_d     = lvl_q - LW'(1);
					res_st_d  = ST_OK;
					res_vld_d = 1'b1;
					state_d   = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = res_vld_q;
	assign status      = res_st_q;
	assign entry_count = COUNT_W'(cnt_q);
	assign scope_level = SCOPE_W'(lvl_q);

endmodule

`default_nettype wire

@@ src/srt_checker.sv @@
// Port-level checker for the scoped root table, bound to the top level.
`default_nettype none

`include "scoped_root_table_assert.svh"

module srt_checker #(
	parameter int unsigned DEPTH     = srt_pkg::DEPTH_DEF,
	parameter int unsigned MAX_SCOPE = srt_pkg::MAX_SCOPE_DEF
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire logic [srt_pkg::FUNC_W-1:0] func,
	input wire logic                       done,
	input wire logic [srt_pkg::COUNT_W-1:0] entry_count,
	input wire logic [srt_pkg::SCOPE_W-1:0] scope_level
);
	import srt_pkg::*;

	// table never holds more than DEPTH entries
	`SRT_ASSERT_NOW(a_count_bound, 1'b1, entry_count <= DEPTH, "entry count above depth")

	// scope level never passes the limit
	`SRT_ASSERT_NOW(a_scope_bound, 1'b1, scope_level <= MAX_SCOPE, "scope level above limit")

	// push scope answers in the very next cycle
	`SRT_ASSERT_NEXT(a_push_fast, start && !busy && (func == FN_PUSH), done,
		"push scope not answered next cycle")

	// a busy period always ends with a result
	`SRT_ASSERT_NOW(a_busy_ends_done, $fell(busy), done, "busy dropped without a result")

endmodule

bind scoped_root_table srt_checker #(
	.DEPTH     (DEPTH),
	.MAX_SCOPE (MAX_SCOPE)
) u_srt_checker (.*);

`default_nettype wire
